[src/sflt_pkg.sv]
`default_nettype none
package sflt_pkg;

  localparam logic [7:0] SOF_BYTE = 8'h01;
  localparam logic [7:0] ACK_BYTE = 8'h06;
  localparam logic [7:0] NAK_BYTE = 8'h15;
  localparam logic [7:0] CAN_BYTE = 8'h18;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_SEND = 2'd2;

  localparam logic [2:0] REG_ACK_TIMEOUT  = 3'd0;
  localparam logic [2:0] REG_MAX_ATTEMPTS = 3'd1;
  localparam logic [2:0] REG_BACKOFF_BASE = 3'd2;
  localparam logic [2:0] REG_BACKOFF_STEP = 3'd3;
  localparam logic [2:0] REG_MAX_FRAME    = 3'd4;

  localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd1600;
  localparam logic [3:0]  MAX_ATTEMPTS_RST = 4'd3;
  localparam logic [15:0] BACKOFF_BASE_RST = 16'd100;
  localparam logic [15:0] BACKOFF_STEP_RST = 16'd1000;
  localparam logic [8:0]  MAX_FRAME_RST    = 9'd257;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_FRAME_BYTE = 4'd1,
    EV_FRAME_GOOD = 4'd2,
    EV_FRAME_BAD  = 4'd3,
    EV_BAD_LEN    = 4'd4,
    EV_STRAY_ACK  = 4'd5,
    EV_STRAY_NAK  = 4'd6,
    EV_STRAY_CAN  = 4'd7,
    EV_TRANSMIT   = 4'd8,
    EV_SENT_OK    = 4'd9,
    EV_SEND_FAIL  = 4'd10,
    EV_BUSY       = 4'd11,
    EV_RETRY_WAIT = 4'd12
  } event_e;

  typedef struct packed {
    logic [15:0] ack_wait_ms;
    logic [3:0]  max_attempts;
    logic [15:0] backoff_base_ms;
    logic [15:0] backoff_step_ms;
    logic [8:0]  max_frame_len;
  } cfg_t;

  typedef struct packed {
    event_e      event_res;
    logic [7:0]  data;
    logic        send_ack;
  } result_t;

endpackage
`default_nettype wire

[src/sflt_engine.sv]
`default_nettype none
module sflt_engine import sflt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire cfg_t       cfg_i,
  output result_t         res_o
);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_LEN   = 2'd1,
    PH_BODY  = 2'd2
  } parse_e;

  typedef enum logic [1:0] {
    SP_IDLE    = 2'd0,
    SP_WAIT    = 2'd1,
    SP_BACKOFF = 2'd2
  } send_e;

  parse_e      parse_q, parse_d;
  send_e       send_q, send_d;
  logic [8:0]  left_q, left_d;
  logic [7:0]  chk_q, chk_d;
  logic [3:0]  att_q, att_d;
  logic [19:0] timer_q, timer_d;

  logic [3:0]  att_next;
  logic [19:0] backoff;
  logic [19:0] backoff_ld;
  logic [19:0] timeout_ld;
  logic        last_attempt;
  logic [8:0]  left_m1;
  logic [8:0]  total_len;

  assign att_next     = att_q + 4'd1;
  assign last_attempt = ({1'b0, att_q} + 5'd1) >= {1'b0, cfg_i.max_attempts};
  assign backoff      = {16'd0, att_next} * {4'd0, cfg_i.backoff_step_ms}
                        + {4'd0, cfg_i.backoff_base_ms};
  assign backoff_ld   = (backoff == '0) ? 20'd1 : backoff;
  assign timeout_ld   = (cfg_i.ack_wait_ms == '0) ? 20'd1
                                                  : {4'd0, cfg_i.ack_wait_ms};
  assign left_m1      = left_q - 9'd1;
  assign total_len    = {1'b0, rx_byte_i} + 9'd2;

  always_comb begin
    parse_d = parse_q;
    send_d  = send_q;
    left_d  = left_q;
    chk_d   = chk_q;
    att_d   = att_q;
    timer_d = timer_q;
    res_o   = '{event_res: EV_NONE, data: 8'd0, send_ack: 1'b0};

    unique case (cmd_i)
      CMD_BYTE: begin
        if (send_q != SP_BACKOFF) begin
          unique case (parse_q)
            PH_LEN: begin
              chk_d = chk_q ^ rx_byte_i;
              if (rx_byte_i < 8'd3 || total_len > cfg_i.max_frame_len) begin
                parse_d = PH_START;
                left_d  = '0;
                chk_d   = 8'hFF;
                res_o.event_res = EV_BAD_LEN;
              end else begin
                left_d  = {1'b0, rx_byte_i};
                parse_d = PH_BODY;
              end
            end
            PH_BODY: begin
              if (left_m1 == '0) begin
                parse_d = PH_START;
                left_d  = '0;
                chk_d   = 8'hFF;
                if (chk_q == rx_byte_i) begin
                  res_o.event_res = EV_FRAME_GOOD;
                  res_o.send_ack  = 1'b1;
                end else begin
                  res_o.event_res = EV_FRAME_BAD;
                end
              end else begin
                left_d = left_m1;
                chk_d  = chk_q ^ rx_byte_i;
                res_o.event_res = EV_FRAME_BYTE;
                res_o.data      = rx_byte_i;
              end
            end
            default: begin
              if (rx_byte_i == ACK_BYTE) begin
                if (send_q == SP_WAIT) begin
                  send_d  = SP_IDLE;
                  timer_d = '0;
                  res_o.event_res = EV_SENT_OK;
                end else begin
                  res_o.event_res = EV_STRAY_ACK;
                end
              end else if (rx_byte_i == NAK_BYTE || rx_byte_i == CAN_BYTE) begin
                if (send_q == SP_WAIT) begin
                  if (last_attempt) begin
                    send_d  = SP_IDLE;
                    timer_d = '0;
                    res_o.event_res = EV_SEND_FAIL;
                  end else begin
                    att_d   = att_next;
                    timer_d = backoff_ld;
                    send_d  = SP_BACKOFF;
                    res_o.event_res = EV_RETRY_WAIT;
                  end
                end else begin
                  res_o.event_res = (rx_byte_i == NAK_BYTE) ? EV_STRAY_NAK : EV_STRAY_CAN;
                end
              end else if (rx_byte_i == SOF_BYTE) begin
                parse_d = PH_LEN;
                chk_d   = 8'hFF;
                left_d  = '0;
              end
            end
          endcase
        end
      end
      CMD_TICK: begin
        if (send_q != SP_IDLE) begin
          if (timer_q > 20'd1) begin
            timer_d = timer_q - 20'd1;
          end else if (send_q == SP_WAIT) begin
            if (last_attempt) begin
              send_d  = SP_IDLE;
              timer_d = '0;
              res_o.event_res = EV_SEND_FAIL;
            end else begin
              att_d   = att_next;
              timer_d = backoff_ld;
              send_d  = SP_BACKOFF;
              res_o.event_res = EV_RETRY_WAIT;
            end
          end else begin
            // backoff over: drop partial frame and retransmit
            parse_d = PH_START;
            left_d  = '0;
            chk_d   = 8'hFF;
            send_d  = SP_WAIT;
            timer_d = timeout_ld;
            res_o.event_res = EV_TRANSMIT;
          end
        end
      end
      CMD_SEND: begin
        if (send_q != SP_IDLE) begin
          res_o.event_res = EV_BUSY;
        end else begin
          att_d   = '0;
          send_d  = SP_WAIT;
          timer_d = timeout_ld;
          res_o.event_res = EV_TRANSMIT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q <= PH_START;
      send_q  <= SP_IDLE;
      left_q  <= '0;
      chk_q   <= 8'hFF;
      att_q   <= '0;
      timer_q <= '0;
    end else if (step_i) begin
      parse_q <= parse_d;
      send_q  <= send_d;
      left_q  <= left_d;
      chk_q   <= chk_d;
      att_q   <= att_d;
      timer_q <= timer_d;
    end
  end

endmodule
`default_nettype wire

[src/serial_frame_link_transport.sv]
// The result of a transaction is registered and appears on the master side in the cycle after
// it is taken. Throughput: one item per cycle while the master side is not stalled; the output
// register lets a new item in while the held result is taken in the same cycle.
// Reset: parser waits for start of frame, no send in progress, output empty, configuration
// registers return to 1600 / 3 / 100 / 1000 / 257.
`default_nettype none
module serial_frame_link_transport import sflt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,   // [7:0] data
  output      logic [4:0]  m_axis_tuser,   // [3:0] event_res, [4] send_ack
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  cfg_t    cfg_q;
  result_t res;
  result_t res_q;
  logic    out_valid_q;
  logic    accept;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_wait_ms     <= ACK_TIMEOUT_RST;
      cfg_q.max_attempts    <= MAX_ATTEMPTS_RST;
      cfg_q.backoff_base_ms <= BACKOFF_BASE_RST;
      cfg_q.backoff_step_ms <= BACKOFF_STEP_RST;
      cfg_q.max_frame_len   <= MAX_FRAME_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ACK_TIMEOUT:  cfg_q.ack_wait_ms     <= cfg_data_i;
        REG_MAX_ATTEMPTS: cfg_q.max_attempts    <= cfg_data_i[3:0];
        REG_BACKOFF_BASE: cfg_q.backoff_base_ms <= cfg_data_i;
        REG_BACKOFF_STEP: cfg_q.backoff_step_ms <= cfg_data_i;
        REG_MAX_FRAME:    cfg_q.max_frame_len   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  sflt_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept),
    .cmd_i     (s_axis_tuser),
    .rx_byte_i (s_axis_tdata),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q.data;
  assign m_axis_tuser  = {res_q.send_ack, res_q.event_res};

  a_ack_only_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.send_ack) |-> (res_q.event_res == EV_FRAME_GOOD))
    else $error("send_ack raised without a good frame");

  a_data_only_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.data != 8'd0) |-> (res_q.event_res == EV_FRAME_BYTE))
    else $error("data present on a non-byte event");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result stalled");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted transaction produced no result");

endmodule
`default_nettype wire

[test/tb.sv]
module tb;
  import sflt_pkg::*;

  localparam int         LIMIT_CYCLES = 3_000_000;
  localparam int         HOLD_CYCLES  = 40;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  typedef enum logic [1:0] {PARSE_START, PARSE_LEN, PARSE_BODY} parse_e;
  typedef enum logic [1:0] {LINK_IDLE, LINK_WAIT_ACK, LINK_BACKOFF} link_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // link model state and its copy of the registers
  cfg_t        link_cfg;
  parse_e      parse_st;
  logic [8:0]  body_left;
  logic [7:0]  run_xor;
  link_e       link_st;
  logic [3:0]  tries;
  logic [19:0] ms_left;

  result_t     expected_q[$];
  int          errors = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  bit          idle_on;
  bit          stall_on;
  bit          hold_req;

  serial_frame_link_transport u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- link model

  function automatic cfg_t mk_cfg(input logic [15:0] ack, input logic [3:0] att,
                                  input logic [15:0] base, input logic [15:0] step,
                                  input logic [8:0] maxf);
    cfg_t c;
    c.ack_wait_ms     = ack;
    c.max_attempts    = att;
    c.backoff_base_ms = base;
    c.backoff_step_ms = step;
    c.max_frame_len   = maxf;
    return c;
  endfunction

  function automatic logic [19:0] min_one(input logic [19:0] v);
    return (v == '0) ? 20'd1 : v;
  endfunction

  function automatic void parser_reset();
    parse_st  = PARSE_START;
    body_left = '0;
    run_xor   = 8'hFF;
  endfunction

  function automatic event_e transmit();
    link_st = LINK_WAIT_ACK;
    ms_left = min_one({4'd0, link_cfg.ack_wait_ms});
    return EV_TRANSMIT;
  endfunction

  // NAK, CAN or ack timeout: fail the send or arm the backoff
  function automatic event_e give_up_or_retry();
    int pause;
    if (int'(tries) + 1 >= int'(link_cfg.max_attempts)) begin
      link_st = LINK_IDLE;
      ms_left = '0;
      return EV_SEND_FAIL;
    end
    tries   = tries + 4'd1;
    pause   = int'(link_cfg.backoff_base_ms) + int'(tries) * int'(link_cfg.backoff_step_ms);
    ms_left = min_one(pause[19:0]);
    link_st = LINK_BACKOFF;
    return EV_RETRY_WAIT;
  endfunction

  function automatic result_t take_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    r.event_res = EV_NONE;
    if (link_st == LINK_BACKOFF) return r;
    case (parse_st)
      PARSE_LEN: begin
        run_xor = run_xor ^ b;
        if (b < 8'd3 || 9'd2 + b > link_cfg.max_frame_len) begin
          parser_reset();
          r.event_res = EV_BAD_LEN;
        end else begin
          body_left = {1'b0, b};
          parse_st  = PARSE_BODY;
        end
      end
      PARSE_BODY: begin
        body_left = body_left - 9'd1;
        if (body_left == '0) begin
          if (run_xor == b) begin
            r.event_res = EV_FRAME_GOOD;
            r.send_ack  = 1'b1;
          end else begin
            r.event_res = EV_FRAME_BAD;
          end
          parser_reset();
        end else begin
          run_xor     = run_xor ^ b;
          r.data      = b;
          r.event_res = EV_FRAME_BYTE;
        end
      end
      default: begin
        if (b == ACK_BYTE) begin
          if (link_st == LINK_WAIT_ACK) begin
            link_st     = LINK_IDLE;
            ms_left     = '0;
            r.event_res = EV_SENT_OK;
          end else begin
            r.event_res = EV_STRAY_ACK;
          end
        end else if (b == NAK_BYTE || b == CAN_BYTE) begin
          if (link_st == LINK_WAIT_ACK) r.event_res = give_up_or_retry();
          else if (b == NAK_BYTE) r.event_res = EV_STRAY_NAK;
          else r.event_res = EV_STRAY_CAN;
        end else if (b == SOF_BYTE) begin
          parse_st  = PARSE_LEN;
          run_xor   = 8'hFF;
          body_left = '0;
        end
      end
    endcase
    return r;
  endfunction

  function automatic event_e take_tick();
    if (link_st == LINK_IDLE) return EV_NONE;
    if (ms_left > 20'd1) begin
      ms_left = ms_left - 20'd1;
      return EV_NONE;
    end
    ms_left = '0;
    if (link_st == LINK_WAIT_ACK) return give_up_or_retry();
    parser_reset();
    return transmit();
  endfunction

  function automatic result_t link_predict(input logic [1:0] cmd, input logic [7:0] b);
    result_t r;
    r = '0;
    r.event_res = EV_NONE;
    case (cmd)
      CMD_BYTE: r = take_byte(b);
      CMD_TICK: r.event_res = take_tick();
      CMD_SEND: begin
        if (link_st != LINK_IDLE) begin
          r.event_res = EV_BUSY;
        end else begin
          tries       = '0;
          r.event_res = transmit();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 3))
      0: return SOF_BYTE;
      1: return ACK_BYTE;
      2: return NAK_BYTE;
      default: return CAN_BYTE;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.insert(expected_q.size(), link_predict(cmd, b));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (expected_q.size() != 0);
  endtask

  task automatic configure(input cfg_t c);
    logic [2:0]  reg_idx [5];
    logic [15:0] reg_val [5];
    reg_idx = '{REG_ACK_TIMEOUT, REG_MAX_ATTEMPTS, REG_BACKOFF_BASE, REG_BACKOFF_STEP,
                REG_MAX_FRAME};
    reg_val = '{c.ack_wait_ms, {12'd0, c.max_attempts}, c.backoff_base_ms,
                c.backoff_step_ms, {7'd0, c.max_frame_len}};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_idx[i];
      cfg_data_i  <= reg_val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    link_cfg = c;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] len, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'hFF ^ len;
    send_item(CMD_BYTE, SOF_BYTE);
    send_item(CMD_BYTE, len);
    for (int i = 1; i < int'(len); i++) begin
      b   = ($urandom_range(0, 7) == 0) ? pick_special() : 8'($urandom);
      sum = sum ^ b;
      if ($urandom_range(0, 15) == 0) send_item(CMD_TICK, 8'($urandom));
      send_item(CMD_BYTE, b);
    end
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    send_item(CMD_BYTE, sum);
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: ev=%0d data=%02h ack=%0d", $time,
                 m_axis_tuser[3:0], m_axis_tdata, m_axis_tuser[4]);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tuser[3:0] !== want.event_res || m_axis_tdata !== want.data ||
            m_axis_tuser[4] !== want.send_ack) begin
          errors++;
          $display("%0t: expected ev=%0d data=%02h ack=%0d, got ev=%0d data=%02h ack=%0d",
                   $time, want.event_res, want.data, want.send_ack,
                   m_axis_tuser[3:0], m_axis_tdata, m_axis_tuser[4]);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_defaults();
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_UNUSED, 8'hFF);
    send_item(CMD_BYTE, ACK_BYTE);
    send_item(CMD_BYTE, NAK_BYTE);
    send_item(CMD_BYTE, CAN_BYTE);
    send_item(CMD_SEND, 8'h00);
    send_item(CMD_SEND, 8'hFF);
    send_frame(8'd3, 1'b0);          // parsed while the send waits for its ACK
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_BYTE, ACK_BYTE);
  endtask

  task automatic test_frame_checks();
    drain();
    configure(mk_cfg(16'd0, MAX_ATTEMPTS_RST, 16'd0, 16'd0, 9'd5));
    send_frame(8'd3, 1'b0);
    send_frame(8'd3, 1'b1);
    send_item(CMD_BYTE, SOF_BYTE);
    send_item(CMD_BYTE, 8'd4);       // one over the frame limit
    send_item(CMD_BYTE, SOF_BYTE);
    send_item(CMD_BYTE, 8'd2);
    send_item(CMD_BYTE, SOF_BYTE);
    send_item(CMD_BYTE, 8'd0);
    // control bytes inside a frame are plain data
    send_item(CMD_BYTE, SOF_BYTE);
    send_item(CMD_BYTE, 8'd3);
    send_item(CMD_BYTE, ACK_BYTE);
    send_item(CMD_BYTE, NAK_BYTE);
    send_item(CMD_BYTE, 8'hFF ^ 8'd3 ^ ACK_BYTE ^ NAK_BYTE);
    drain();
    configure(mk_cfg(ACK_TIMEOUT_RST, MAX_ATTEMPTS_RST, BACKOFF_BASE_RST, BACKOFF_STEP_RST,
                     MAX_FRAME_RST));
    send_frame(8'd255, 1'b0);
  endtask

  task automatic test_retries();
    drain();
    configure(mk_cfg(16'd0, 4'd2, 16'd0, 16'd0, MAX_FRAME_RST));
    send_item(CMD_SEND, 8'h00);
    send_item(CMD_BYTE, SOF_BYTE);   // parser left waiting for a length
    send_item(CMD_TICK, 8'h00);      // zero timeout ends on the first tick
    send_item(CMD_BYTE, 8'h07);      // flushed during backoff
    send_item(CMD_SEND, 8'h00);
    send_item(CMD_TICK, 8'h00);      // backoff over, parser cleared, retransmit
    send_item(CMD_BYTE, 8'h03);      // junk now, not a length
    send_item(CMD_BYTE, NAK_BYTE);   // last attempt used up
    drain();
    configure(mk_cfg(16'd2, 4'd1, 16'd1, 16'd1, MAX_FRAME_RST));
    send_item(CMD_SEND, 8'h00);
    send_item(CMD_BYTE, CAN_BYTE);
  endtask

  task automatic test_extremes();
    drain();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    configure(mk_cfg(16'hFFFF, 4'd15, 16'hFFFF, 16'hFFFF, MAX_FRAME_RST));
    send_item(CMD_SEND, 8'hFF);
    repeat (3) send_item(CMD_TICK, 8'($urandom));
    send_item(CMD_BYTE, ACK_BYTE);
    drain();
    configure(mk_cfg(16'd1, 4'd15, 16'd40, 16'd3, MAX_FRAME_RST));
    send_item(CMD_SEND, 8'h00);
    send_item(CMD_TICK, 8'h00);
    repeat (43) send_item(CMD_TICK, 8'($urandom));   // last one ends the backoff
    send_item(CMD_BYTE, ACK_BYTE);
    drain();
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_hold_off();
    drain();
    configure(mk_cfg(16'd4, 4'd2, 16'd1, 16'd1, MAX_FRAME_RST));
    hold_req = 1'b1;
    send_item(CMD_SEND, 8'h00);
    repeat (3) send_frame(8'd6, 1'b0);
    send_item(CMD_BYTE, ACK_BYTE);
  endtask

  task automatic test_random();
    int target;
    int maxlen;
    int len;
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      configure(mk_cfg(16'($urandom_range(0, 6)),
                       ($urandom_range(0, 5) == 0) ? 4'd15 : 4'($urandom_range(1, 4)),
                       16'($urandom_range(0, 3)), 16'($urandom_range(0, 2)),
                       ($urandom_range(0, 2) == 0) ? 9'd257 : 9'($urandom_range(5, 24))));
      if (phase == 3) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      maxlen = int'(link_cfg.max_frame_len) - 2;
      target = items_sent + 100;
      while (items_sent < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            if ($urandom_range(0, 19) == 0) len = $urandom_range(3, maxlen);
            else len = $urandom_range(3, (maxlen < 10) ? maxlen : 10);
            send_frame(8'(len), $urandom_range(0, 5) == 0);
          end
          4: begin
            send_item(CMD_SEND, 8'($urandom));
            case ($urandom_range(0, 3))
              0: send_item(CMD_BYTE, ACK_BYTE);
              1: send_item(CMD_BYTE, NAK_BYTE);
              2: send_item(CMD_BYTE, CAN_BYTE);
              default: ;
            endcase
          end
          5: repeat ($urandom_range(1, 8)) send_item(CMD_TICK, 8'($urandom));
          6: begin
            send_item(CMD_BYTE, SOF_BYTE);
            if (maxlen < 255 && $urandom_range(0, 1) == 0) len = $urandom_range(maxlen + 1, 255);
            else len = $urandom_range(0, 2);
            send_item(CMD_BYTE, 8'(len));
          end
          7: send_item(CMD_BYTE, ($urandom_range(0, 1) == 0) ? pick_special() : 8'($urandom));
          8: begin
            // cut-off frame: whatever comes next lands in its body
            send_item(CMD_BYTE, SOF_BYTE);
            len = $urandom_range(3, (maxlen < 10) ? maxlen : 10);
            send_item(CMD_BYTE, 8'(len));
            repeat ($urandom_range(0, len - 1)) send_item(CMD_BYTE, 8'($urandom));
          end
          default: send_item(CMD_UNUSED, 8'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = CMD_BYTE;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_ACK_TIMEOUT;
    cfg_data_i    = 16'h0000;
    idle_on       = 1'b1;
    stall_on      = 1'b1;
    hold_req      = 1'b0;
    link_cfg = mk_cfg(ACK_TIMEOUT_RST, MAX_ATTEMPTS_RST, BACKOFF_BASE_RST, BACKOFF_STEP_RST,
                      MAX_FRAME_RST);
    parser_reset();
    link_st = LINK_IDLE;
    tries   = '0;
    ms_left = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_defaults();
    test_frame_checks();
    test_retries();
    test_extremes();
    test_hold_off();
    test_random();

    drain();
    repeat (4) @(negedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/sflt_pkg.sv
src/sflt_engine.sv
src/serial_frame_link_transport.sv
test/tb.sv
